// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file vna_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge out of reset
`define VNA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vna assertion failed");

// antecedent in one cycle implies consequent in the next
`define VNA_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("vna assertion failed");

`endif

// ----- rtl/vna_pkg.sv -----
// shared types and constants of the vertex normal accumulator
// no dependencies
package vna_pkg;

  localparam int IDX_W       = 10;
  localparam int FIELD_W     = 16;
  localparam int COORD_MAX_W = 24;
  localparam int NORM_W      = 16;
  localparam int MAG_W       = 30;   // normalized magnitude width
  localparam int SQRT_W      = 64;
  localparam int LEN_W       = 32;
  localparam int DIV_W       = 48;
  localparam int QUOT_W      = 16;
  localparam int FRAC_BITS   = 14;

  localparam logic [NORM_W-1:0] ONE_Q14        = 16'd16384;
  localparam logic [11:0]       DEGEN_SQ_LIMIT = 12'd281;
  localparam int                DEGEN_TOP      = 16;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_READ     = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
    logic                     saturated;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e                op;
    logic               oob;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] cx;
    logic [FIELD_W-1:0] cy;
    logic [FIELD_W-1:0] cz;
    logic [IDX_W-1:0]   ca;
    logic [IDX_W-1:0]   cb;
    logic [IDX_W-1:0]   cc;
  } cmd_t;

endpackage

// ----- rtl/vna_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/vna_front.sv -----
// front end: accepts items, checks indexes, queues commands for the back end
// depends on vna_pkg
module vna_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vna_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output vna_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);
  import vna_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full, keep, push;
  logic             idx_ok, a_ok, b_ok, c_ok;
  cmd_t             cmd_new;

  assign idx_ok = 32'(in_item_i.vertex_index) < MAX_VERTICES;
  assign a_ok   = 32'(in_item_i.corner_a) < MAX_VERTICES;
  assign b_ok   = 32'(in_item_i.corner_b) < MAX_VERTICES;
  assign c_ok   = 32'(in_item_i.corner_c) < MAX_VERTICES;

  always_comb begin
    case (op_e'(in_item_i.operation))
      OP_LOAD:     keep = idx_ok;
      OP_TRIANGLE: keep = a_ok && b_ok && c_ok;
      OP_READ:     keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd_new.op  = op_e'(in_item_i.operation);
    cmd_new.oob = !idx_ok;
    cmd_new.idx = in_item_i.vertex_index;
    cmd_new.cx  = in_item_i.coord_x;
    cmd_new.cy  = in_item_i.coord_y;
    cmd_new.cz  = in_item_i.coord_z;
    cmd_new.ca  = in_item_i.corner_a;
    cmd_new.cb  = in_item_i.corner_b;
    cmd_new.cc  = in_item_i.corner_c;
  end

  assign full        = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full && keep;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end
endmodule

// ----- rtl/vna_back.sv -----
// back end: sequencer over vertex and accumulator rams, cross product,
// saturating accumulate, normalize, square root and division; depends on vna_pkg, vna_ram
module vna_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 16,
  parameter int SUM_WIDTH    = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  vna_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vna_pkg::out_item_t out_item_o
);
  import vna_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int SW   = SUM_WIDTH;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int DW   = PW + 1;
  localparam int XW   = ((SW > DW) ? SW : DW) + 1;
  localparam int VW   = 3 * CW;
  localparam int SRW  = 3 * SW + 1;
  localparam logic signed [XW-1:0] SUM_HI = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [XW-1:0] SUM_LO = ~SUM_HI;

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_LOAD     = 19'h00002,
    ST_VRD_A    = 19'h00004,
    ST_VRD_B    = 19'h00008,
    ST_VRD_C    = 19'h00010,
    ST_EDGE     = 19'h00020,
    ST_MUL      = 19'h00040,
    ST_CROSS    = 19'h00080,
    ST_ACC_RD   = 19'h00100,
    ST_ACC_WR   = 19'h00200,
    ST_SUM_RD   = 19'h00400,
    ST_SUM_CAP  = 19'h00800,
    ST_TOP      = 19'h01000,
    ST_NORM     = 19'h02000,
    ST_SQ       = 19'h04000,
    ST_SQRT     = 19'h08000,
    ST_DIV_INIT = 19'h10000,
    ST_DIV      = 19'h20000,
    ST_EMIT     = 19'h40000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q;

  logic [VW-1:0]        va_q, vb_q, vrd;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] prod_q [6];
  logic signed [DW-1:0] n_q [3];
  logic [2:0]           cnt_q;
  logic [1:0]           ccnt_q;
  logic [3:0]           kcnt_q;

  logic [SW-1:0]        m_q [3];
  logic                 sgn_q [3];
  logic [SW-1:0]        top_q;
  logic [2*MAG_W-1:0]   sqp_q;
  logic [SQRT_W-1:0]    sumsq_q, v_q, res_q, bit_q;
  logic [LEN_W-1:0]     len_q;
  logic [DIV_W-1:0]     rem_q, dsh_q;
  logic [QUOT_W-2:0]    q_q;
  logic [NORM_W-1:0]    nrm_q [3];
  logic                 deg_q, sat_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  // ram ports
  logic            v_we, s_we;
  logic [AW-1:0]   v_raddr, s_raddr, s_waddr, corner_addr;
  logic [VW-1:0]   v_wdata;
  logic [SRW-1:0]  s_wdata, srd;
  logic [COORD_MAX_W-1:0] ext_x, ext_y, ext_z;

  // datapath helpers
  logic signed [EW-1:0] opa, opb;
  logic signed [PW-1:0] mul;
  logic signed [XW-1:0] acc_w [3];
  logic signed [XW-1:0] add_w [3];
  logic [SW-1:0]        nsum [3];
  logic                 hit [3];
  logic [SW-1:0]        mag [3];
  logic [SW-1:0]        t01, top_c;
  logic [11:0]          small_sq;
  logic                 is_degen;
  logic [MAG_W-1:0]     sq_op;
  logic [SQRT_W-1:0]    rb, res_n;
  logic                 sq_ge, dv_ge, emit_ok;
  logic [QUOT_W-1:0]    qf, qc, comp;

  assign ext_x   = COORD_MAX_W'(cmd_q.cx);
  assign ext_y   = COORD_MAX_W'(cmd_q.cy);
  assign ext_z   = COORD_MAX_W'(cmd_q.cz);
  assign v_wdata = {ext_z[CW-1:0], ext_y[CW-1:0], ext_x[CW-1:0]};
  assign v_we    = state_q == ST_LOAD;

  always_comb begin
    case (state_q)
      ST_VRD_A: v_raddr = AW'(cmd_q.ca);
      ST_VRD_B: v_raddr = AW'(cmd_q.cb);
      default:  v_raddr = AW'(cmd_q.cc);
    endcase
  end

  always_comb begin
    case (ccnt_q)
      2'd0:    corner_addr = AW'(cmd_q.ca);
      2'd1:    corner_addr = AW'(cmd_q.cb);
      default: corner_addr = AW'(cmd_q.cc);
    endcase
  end

  assign s_we    = (state_q == ST_LOAD) || (state_q == ST_ACC_WR);
  assign s_waddr = (state_q == ST_LOAD) ? AW'(cmd_q.idx) : corner_addr;
  assign s_raddr = (state_q == ST_ACC_RD) ? corner_addr : AW'(cmd_q.idx);
  assign s_wdata = (state_q == ST_LOAD) ? '0 :
                   {srd[3*SW] | hit[0] | hit[1] | hit[2], nsum[2], nsum[1], nsum[0]};

  vna_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (AW'(cmd_q.idx)),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (vrd)
  );

  vna_ram #(.WIDTH(SRW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (srd)
  );

  // shared cross-product multiplier
  always_comb begin
    case (cnt_q)
      3'd0:    begin opa = e1_q[1]; opb = e2_q[2]; end
      3'd1:    begin opa = e1_q[2]; opb = e2_q[1]; end
      3'd2:    begin opa = e1_q[2]; opb = e2_q[0]; end
      3'd3:    begin opa = e1_q[0]; opb = e2_q[2]; end
      3'd4:    begin opa = e1_q[0]; opb = e2_q[1]; end
      3'd5:    begin opa = e1_q[1]; opb = e2_q[0]; end
      default: begin opa = e1_q[0]; opb = e2_q[0]; end
    endcase
  end
  assign mul = opa * opb;

  // saturating accumulate and magnitudes
  for (genvar i = 0; i < 3; i++) begin : g_comp
    assign acc_w[i] = XW'($signed(srd[i*SW +: SW]));
    assign add_w[i] = acc_w[i] + XW'(n_q[i]);
    always_comb begin
      hit[i]  = 1'b0;
      nsum[i] = add_w[i][SW-1:0];
      if (add_w[i] > SUM_HI) begin
        hit[i]  = 1'b1;
        nsum[i] = SUM_HI[SW-1:0];
      end else if (add_w[i] < SUM_LO) begin
        hit[i]  = 1'b1;
        nsum[i] = SUM_LO[SW-1:0];
      end
    end
    assign mag[i] = srd[i*SW+SW-1] ? (~srd[i*SW +: SW] + 1'b1) : srd[i*SW +: SW];
  end

  assign t01      = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
  assign top_c    = (t01 > m_q[2]) ? t01 : m_q[2];
  assign small_sq = 12'(m_q[0][4:0] * m_q[0][4:0]) + 12'(m_q[1][4:0] * m_q[1][4:0])
                  + 12'(m_q[2][4:0] * m_q[2][4:0]);
  assign is_degen = (top_c <= SW'(DEGEN_TOP)) && (small_sq <= DEGEN_SQ_LIMIT);

  always_comb begin
    case (cnt_q)
      3'd0:    sq_op = m_q[0][MAG_W-1:0];
      3'd1:    sq_op = m_q[1][MAG_W-1:0];
      default: sq_op = m_q[2][MAG_W-1:0];
    endcase
  end

  // one square-root step per cycle
  assign rb    = res_q + bit_q;
  assign sq_ge = v_q >= rb;
  assign res_n = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  // one restoring-division step per cycle
  assign dv_ge = rem_q >= dsh_q;
  assign qf    = {q_q, dv_ge};
  assign qc    = (qf > ONE_Q14) ? ONE_Q14 : qf;
  assign comp  = sgn_q[ccnt_q] ? (~qc + 1'b1) : qc;

  assign emit_ok   = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_LOAD:     state_d = ST_LOAD;
            OP_TRIANGLE: state_d = ST_VRD_A;
            OP_READ:     state_d = cmd_i.oob ? ST_EMIT : ST_SUM_RD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:     state_d = ST_IDLE;
      ST_VRD_A:    state_d = ST_VRD_B;
      ST_VRD_B:    state_d = ST_VRD_C;
      ST_VRD_C:    state_d = ST_EDGE;
      ST_EDGE:     state_d = ST_MUL;
      ST_MUL:      state_d = (cnt_q == 3'd5) ? ST_CROSS : ST_MUL;
      ST_CROSS:    state_d = ST_ACC_RD;
      ST_ACC_RD:   state_d = ST_ACC_WR;
      ST_ACC_WR:   state_d = (ccnt_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_SUM_RD:   state_d = ST_SUM_CAP;
      ST_SUM_CAP:  state_d = ST_TOP;
      ST_TOP:      state_d = is_degen ? ST_EMIT : ST_NORM;
      ST_NORM: begin
        if ((top_q >> MAG_W) == '0 && top_q[MAG_W-1]) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ:       state_d = (cnt_q == 3'd3) ? ST_SQRT : ST_SQ;
      ST_SQRT:     state_d = bit_q[0] ? ST_DIV_INIT : ST_SQRT;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (kcnt_q == '0) begin
          state_d = (ccnt_q == 2'd2) ? ST_EMIT : ST_DIV_INIT;
        end
      end
      ST_EMIT:     state_d = emit_ok ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q <= cmd_i;
        cnt_q <= '0;
        if (cmd_i.oob) begin
          for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
          deg_q <= 1'b1;
          sat_q <= 1'b0;
        end
      end
      ST_VRD_B: va_q <= vrd;
      ST_VRD_C: vb_q <= vrd;
      ST_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= $signed({vb_q[i*CW+CW-1], vb_q[i*CW +: CW]})
                   - $signed({va_q[i*CW+CW-1], va_q[i*CW +: CW]});
          e2_q[i] <= $signed({vrd[i*CW+CW-1], vrd[i*CW +: CW]})
                   - $signed({va_q[i*CW+CW-1], va_q[i*CW +: CW]});
        end
      end
      ST_MUL: begin
        prod_q[cnt_q] <= mul;
        cnt_q         <= cnt_q + 1'b1;
      end
      ST_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          n_q[i] <= DW'(prod_q[2*i]) - DW'(prod_q[2*i+1]);
        end
        ccnt_q <= '0;
      end
      ST_ACC_WR: ccnt_q <= ccnt_q + 1'b1;
      ST_SUM_CAP: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= mag[i];
          sgn_q[i] <= srd[i*SW+SW-1];
        end
        sat_q <= srd[3*SW];
      end
      ST_TOP: begin
        top_q <= top_c;
        cnt_q <= '0;
        if (is_degen) begin
          for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
          deg_q <= 1'b1;
        end else begin
          deg_q <= 1'b0;
        end
      end
      ST_NORM: begin
        if ((top_q >> MAG_W) != '0) begin
          top_q <= top_q >> 1;
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (!top_q[MAG_W-1]) begin
          top_q <= top_q << 1;
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
        sumsq_q <= '0;
      end
      ST_SQ: begin
        sqp_q <= sq_op * sq_op;
        if (cnt_q != '0) begin
          sumsq_q <= sumsq_q + SQRT_W'(sqp_q);
        end
        cnt_q <= cnt_q + 1'b1;
        v_q   <= sumsq_q + SQRT_W'(sqp_q);
        res_q <= '0;
        bit_q <= SQRT_W'(1) << (SQRT_W - 2);
      end
      ST_SQRT: begin
        if (sq_ge) begin
          v_q <= v_q - rb;
        end
        res_q  <= res_n;
        bit_q  <= bit_q >> 2;
        len_q  <= res_n[LEN_W-1:0];
        ccnt_q <= '0;
      end
      ST_DIV_INIT: begin
        rem_q  <= DIV_W'({m_q[ccnt_q][MAG_W-1:0], {FRAC_BITS{1'b0}}})
                + DIV_W'(len_q >> 1);
        dsh_q  <= DIV_W'(len_q) << (QUOT_W - 1);
        kcnt_q <= 4'(QUOT_W - 1);
        q_q    <= '0;
      end
      ST_DIV: begin
        if (dv_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q  <= dsh_q >> 1;
        q_q    <= qf[QUOT_W-2:0];
        kcnt_q <= kcnt_q - 1'b1;
        if (kcnt_q == '0) begin
          nrm_q[ccnt_q] <= comp;
          ccnt_q        <= ccnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_item_q.normal_x   <= nrm_q[0];
          out_item_q.normal_y   <= nrm_q[1];
          out_item_q.normal_z   <= nrm_q[2];
          out_item_q.degenerate <= deg_q;
          out_item_q.saturated  <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
endmodule

// ----- rtl/vertex_normal_accumulator_top.sv -----
// top level of the area-weighted vertex normal accumulator
// depends on vna_pkg, vna_front, vna_back (and vna_ram below it)
// a read normalizes the magnitudes by shifting, takes a 32-step square root and then
//   divides each component in turn; a near-zero sum goes straight to the result register
// throughput: one item at a time in the back end; a 2-entry command queue and an output
//   register let the input keep taking items while a result waits; reset clears control only
module vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 16,
  parameter int SUM_WIDTH    = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vna_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vna_pkg::out_item_t out_item_o
);
  import vna_pkg::*;

  // queued command between front and back
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: index checks, drops ignored items, queues the rest
  vna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: memories, arithmetic and the result register
  vna_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );
endmodule

// ----- rtl/vna_checker.sv -----
// port-level assertions for the vertex normal accumulator, bound to the top level
// depends on vna_pkg and assert_macros.svh
`include "assert_macros.svh"
module vna_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input vna_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input vna_pkg::out_item_t out_item_o
);
  `VNA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `VNA_ASSERT(a_degen_zero, clk_i, rst_ni, (out_valid_o && out_item_o.degenerate) |-> (out_item_o.normal_x == 0 && out_item_o.normal_y == 0 && out_item_o.normal_z == 0))
  `VNA_ASSERT(a_unit_nonzero, clk_i, rst_ni, (out_valid_o && !out_item_o.degenerate) |-> (out_item_o.normal_x != 0 || out_item_o.normal_y != 0 || out_item_o.normal_z != 0))
  `VNA_ASSERT(a_range_x, clk_i, rst_ni, out_valid_o |-> ($signed(out_item_o.normal_x) <= 16'sd16384 && $signed(out_item_o.normal_x) >= -16'sd16384))
endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (.*);

// ----- verif/tb_top.sv -----
// self-checking testbench for vertex_normal_accumulator_top
// depends on vna_pkg and the rtl below vertex_normal_accumulator_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vna_pkg::*;

  localparam int NV = 1024;
  localparam int IN_W = $bits(in_item_t);
  localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint unsigned DEGEN_LIMIT = 281;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  vertex_normal_accumulator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the vertex store, the normal sums and the overflow marks
  int        pos_x [NV];
  int        pos_y [NV];
  int        pos_z [NV];
  longint    nsum_x [NV];
  longint    nsum_y [NV];
  longint    nsum_z [NV];
  bit        ovf_mark [NV];

  out_item_t normal_q[$];     // normals still owed by the block
  int        fail_cnt = 0;
  bit        calm = 1'b0;     // no idling on either side while set
  bit        hold_req = 1'b0; // asks the receiver for one long hold-off
  bit        row_typed = 1'b0;
  out_item_t row_normal = '0;

  // generator-side view of which slots hold a vertex
  bit        is_loaded [NV];
  int        loaded_q[$];

  // a table row: one item, sent reps times, with a typed-in normal for reads
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t normal;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic longint sat_sum(longint acc, longint d, inout bit hit);
    if (d > 0 && acc > SUM_HI - d) begin
      hit = 1'b1;
      return SUM_HI;
    end
    if (d < 0 && acc < SUM_LO - d) begin
      hit = 1'b1;
      return SUM_LO;
    end
    return acc + d;
  endfunction

  function automatic void add_normal(int v, longint nx, longint ny, longint nz);
    bit hit;
    hit = 1'b0;
    nsum_x[v] = sat_sum(nsum_x[v], nx, hit);
    nsum_y[v] = sat_sum(nsum_y[v], ny, hit);
    nsum_z[v] = sat_sum(nsum_z[v], nz, hit);
    if (hit) ovf_mark[v] = 1'b1;
  endfunction

  function automatic void add_triangle(int a, int b, int c);
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    e1x = longint'(pos_x[b]) - pos_x[a];
    e1y = longint'(pos_y[b]) - pos_y[a];
    e1z = longint'(pos_z[b]) - pos_z[a];
    e2x = longint'(pos_x[c]) - pos_x[a];
    e2y = longint'(pos_y[c]) - pos_y[a];
    e2z = longint'(pos_z[c]) - pos_z[a];
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    add_normal(a, nx, ny, nz);
    add_normal(b, nx, ny, nz);
    add_normal(c, nx, ny, nz);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // unit normal in q1.14 from the accumulated sums of one vertex
  function automatic out_item_t unit_normal(int v);
    longint            s [3];
    longint unsigned   m [3];
    longint unsigned   top, sq, len, q;
    longint            comp;
    logic [NORM_W-1:0] res [3];
    out_item_t         r;
    r = '0;
    r.saturated = ovf_mark[v];
    s[0] = nsum_x[v];
    s[1] = nsum_y[v];
    s[2] = nsum_z[v];
    top = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = s[i] < 0 ? longint'(-s[i]) : s[i];
      if (m[i] > top) top = m[i];
    end
    // near zero length gives zeros and the degenerate flag
    if (top <= 16) begin
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (sq <= DEGEN_LIMIT) begin
        r.degenerate = 1'b1;
        return r;
      end
    end
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = floor_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      comp = s[i] < 0 ? -longint'(q) : longint'(q);
      res[i] = comp[NORM_W-1:0];
    end
    r.normal_x = res[0];
    r.normal_y = res[1];
    r.normal_z = res[2];
    return r;
  endfunction

  // every accepted load, triangle or read transfer updates the shadow state
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      case (op_e'(in_item_i.operation))
        OP_LOAD: begin
          pos_x[in_item_i.vertex_index] = int'(in_item_i.coord_x);
          pos_y[in_item_i.vertex_index] = int'(in_item_i.coord_y);
          pos_z[in_item_i.vertex_index] = int'(in_item_i.coord_z);
          nsum_x[in_item_i.vertex_index] = 0;
          nsum_y[in_item_i.vertex_index] = 0;
          nsum_z[in_item_i.vertex_index] = 0;
          ovf_mark[in_item_i.vertex_index] = 1'b0;
        end
        OP_TRIANGLE: begin
          add_triangle(int'(in_item_i.corner_a), int'(in_item_i.corner_b),
                       int'(in_item_i.corner_c));
        end
        OP_READ: begin
          if (row_typed) normal_q.insert(normal_q.size(), row_normal);
          else normal_q.insert(normal_q.size(), unit_normal(int'(in_item_i.vertex_index)));
        end
        default: ;
      endcase
    end
  end

  // every accepted output transfer is checked against the oldest owed normal
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        $error("output transfer with no normal owed");
        fail_cnt++;
      end else begin
        want = normal_q.pop_front();
        if (out_item_o.normal_x !== want.normal_x) begin
          $error("normal_x expected %0d got %0d", want.normal_x, out_item_o.normal_x);
          fail_cnt++;
        end
        if (out_item_o.normal_y !== want.normal_y) begin
          $error("normal_y expected %0d got %0d", want.normal_y, out_item_o.normal_y);
          fail_cnt++;
        end
        if (out_item_o.normal_z !== want.normal_z) begin
          $error("normal_z expected %0d got %0d", want.normal_z, out_item_o.normal_z);
          fail_cnt++;
        end
        if (out_item_o.degenerate !== want.degenerate) begin
          $error("degenerate expected %0b got %0b", want.degenerate, out_item_o.degenerate);
          fail_cnt++;
        end
        if (out_item_o.saturated !== want.saturated) begin
          $error("saturated expected %0b got %0b", want.saturated, out_item_o.saturated);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: random stall before each transfer, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        n = 400;
        hold_req = 1'b0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // sender: optional gap, then hold the item until the block takes it
  task automatic send_item(in_item_t it, bit typed, out_item_t nrm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    row_typed  <= typed;
    row_normal <= nrm;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic in_item_t load_item(int v, int x, int y, int z);
    in_item_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.vertex_index = IDX_W'(v);
    it.coord_x = FIELD_W'(x);
    it.coord_y = FIELD_W'(y);
    it.coord_z = FIELD_W'(z);
    return it;
  endfunction

  function automatic in_item_t tri_item(int a, int b, int c);
    in_item_t it;
    it = '0;
    it.operation = OP_TRIANGLE;
    it.corner_a = IDX_W'(a);
    it.corner_b = IDX_W'(b);
    it.corner_c = IDX_W'(c);
    return it;
  endfunction

  function automatic in_item_t read_item(int v);
    in_item_t it;
    it = '0;
    it.operation = OP_READ;
    it.vertex_index = IDX_W'(v);
    return it;
  endfunction

  function automatic out_item_t mk_normal(int x, int y, int z, bit dg, bit st);
    out_item_t r;
    r.normal_x = NORM_W'(x);
    r.normal_y = NORM_W'(y);
    r.normal_z = NORM_W'(z);
    r.degenerate = dg;
    r.saturated = st;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, int reps = 1, bit typed = 0,
                                  out_item_t nrm = '0);
    stim_row_t row;
    row.item = it;
    row.reps = reps;
    row.typed = typed;
    row.normal = nrm;
    stim_table.insert(stim_table.size(), row);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return int'($signed(16'($urandom_range(0, 63)))) - 32;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
  endfunction

  function automatic void note_load(int v);
    if (!is_loaded[v]) begin
      is_loaded[v] = 1'b1;
      loaded_q.insert(loaded_q.size(), v);
    end
  endfunction

  initial begin
    in_item_t it;
    int       v, wait_cnt;

    // directed table: unit axes, extremes, near zero length, large sums
    add_row(load_item(0, 0, 0, 0));
    add_row(load_item(1, 4096, 0, 0));
    add_row(load_item(2, 0, 4096, 0));
    add_row(tri_item(0, 1, 2));
    add_row(read_item(0), 1, 1'b1, mk_normal(0, 0, 16384, 0, 0));
    add_row(load_item(3, 100, -100, 7));
    add_row(read_item(3), 1, 1'b1, mk_normal(0, 0, 0, 1, 0));
    add_row(load_item(4, -32768, -32768, -32768));
    add_row(load_item(5, 32767, 32767, 32767));
    add_row(load_item(6, 32767, -32768, 0));
    add_row(tri_item(4, 5, 6));
    add_row(read_item(4));
    add_row(read_item(6));
    // tiny triangle: length below the degenerate limit
    add_row(load_item(7, 0, 0, 0));
    add_row(load_item(8, 1, 0, 0));
    add_row(load_item(9, 0, 1, 0));
    add_row(tri_item(7, 8, 9));
    add_row(read_item(7), 1, 1'b1, mk_normal(0, 0, 0, 1, 0));
    // undefined operation with every field at its top value
    it = '1;
    add_row(it);
    // one widest triangle repeated back to back: large negative x sums
    add_row(load_item(20, 0, -32768, 0));
    add_row(load_item(21, 0, 32767, 32767));
    add_row(load_item(22, 0, 32767, -32768));
    add_row(tri_item(20, 21, 22), 200);
    add_row(read_item(21), 1, 1'b1, mk_normal(-16384, 0, 0, 0, 0));
    add_row(read_item(22));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_table[i]) begin
      calm = stim_table[i].reps > 1;
      if (stim_table[i].item.operation == OP_LOAD)
        note_load(int'(stim_table[i].item.vertex_index));
      repeat (stim_table[i].reps)
        send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].normal);
    end
    calm = 1'b0;

    // random part: mostly loads, triangles and reads on loaded vertices
    for (int n = 0; n < 1450; n++) begin
      if (n % 150 == 75) calm = ~calm;
      if (n == 900) hold_req = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NV - 1)
                                          : $urandom_range(0, 47);
          it = load_item(v, rand_coord(), rand_coord(), rand_coord());
          it.corner_a = IDX_W'($urandom());
          it.corner_b = IDX_W'($urandom());
          it.corner_c = IDX_W'($urandom());
          note_load(v);
        end
        5, 6, 7, 8, 9, 10, 11, 12: begin
          it = tri_item(pick_loaded(), pick_loaded(), pick_loaded());
          it.vertex_index = IDX_W'($urandom());
          it.coord_x = FIELD_W'($urandom());
          it.coord_y = FIELD_W'($urandom());
          it.coord_z = FIELD_W'($urandom());
        end
        13, 14, 15, 16, 17, 18: begin
          it = read_item(pick_loaded());
          it.coord_x = FIELD_W'($urandom());
          it.coord_y = FIELD_W'($urandom());
          it.coord_z = FIELD_W'($urandom());
          it.corner_a = IDX_W'($urandom());
          it.corner_b = IDX_W'($urandom());
          it.corner_c = IDX_W'($urandom());
        end
        default: begin
          it = in_item_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
          it.operation = OP_NONE;
        end
      endcase
      send_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    wait_cnt = 0;
    while (normal_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0 && normal_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      if (normal_q.size() != 0) $error("%0d normals never delivered", normal_q.size());
      $display("tb_top failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #60ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/vna_pkg.sv
rtl/vna_ram.sv
rtl/vna_front.sv
rtl/vna_back.sv
rtl/vertex_normal_accumulator_top.sv
rtl/vna_checker.sv
verif/tb_top.sv
